FILE: hdl/bwd_pkg.sv
// Shared constants for the wheel drive: widths, register indexes, divider layout.
package bwd_pkg;

   localparam int RANGE_BITS = 16;
   localparam int SPEED_W    = 25;
   localparam int QUO_W      = 17;
   localparam int DIV_STEPS  = 2;
   localparam int DIV_STAGES = (QUO_W + DIV_STEPS - 1) / DIV_STEPS;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 2;
   localparam int WIRING_W   = 2;

   localparam logic [CSR_IDX_W-1:0] IDX_WIRING   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] IDX_POLARITY = 1'd1;

   localparam logic [WIRING_W-1:0] WIRING_SAME     = 2'd0;
   localparam logic [WIRING_W-1:0] WIRING_CROSSED  = 2'd1;
   localparam logic [WIRING_W-1:0] WIRING_COMBINED = 2'd2;

   localparam logic POLARITY_INHIBIT = 1'b0;
   localparam logic POLARITY_EXCITE  = 1'b1;

   // initial remainders: 2^24 >> QUO_W and 2^25 >> QUO_W
   localparam int INIT_REM_ONE = 128;
   localparam int INIT_REM_TWO = 256;

endpackage

FILE: hdl/bwd_div.sv
// Pipelined restoring divider: fixed-numerator quotient, up to DIV_STEPS quotient bits per stage.
module bwd_div #(
   parameter int DIV_W = bwd_pkg::RANGE_BITS + 2
) (
   input  logic                                clock,
   input  logic [bwd_pkg::DIV_STAGES-1:0]      en,
   input  logic [DIV_W-1:0]                    rem_init,
   input  logic [DIV_W-1:0]                    divisor,
   output logic [bwd_pkg::QUO_W-1:0]           quotient,
   output logic [DIV_W-1:0]                    divisor_out
);

   localparam int STAGES = bwd_pkg::DIV_STAGES;
   localparam int QW     = bwd_pkg::QUO_W;
   localparam int STEPS  = bwd_pkg::DIV_STEPS;

   logic [DIV_W-1:0] rem_ff [STAGES];
   logic [QW-1:0]    quo_ff [STAGES];
   logic [DIV_W-1:0] div_ff [STAGES];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      localparam int FIRST = s * STEPS;
      localparam int NSTEP = (QW - FIRST < STEPS) ? QW - FIRST : STEPS;

      logic [DIV_W-1:0] rem_src;
      logic [QW-1:0]    quo_src;
      logic [DIV_W-1:0] div_src;
      logic [DIV_W-1:0] rem_in;
      logic [QW-1:0]    quo_in;

      if (s == 0) begin : g_head
         assign rem_src = rem_init;
         assign quo_src = '0;
         assign div_src = divisor;
      end else begin : g_body
         assign rem_src = rem_ff[s-1];
         assign quo_src = quo_ff[s-1];
         assign div_src = div_ff[s-1];
      end

      always_comb begin : step
         logic [DIV_W:0] shifted;
         shifted = '0;
         rem_in  = rem_src;
         quo_in  = quo_src;
         for (int j = 0; j < NSTEP; j++) begin
            shifted = {rem_in, 1'b0};
            if (shifted >= {1'b0, div_src}) begin
               rem_in = DIV_W'(shifted - {1'b0, div_src});
               quo_in = {quo_in[QW-2:0], 1'b1};
            end else begin
               rem_in = shifted[DIV_W-1:0];
               quo_in = {quo_in[QW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en[s]) begin
            rem_ff[s] <= rem_in;
            quo_ff[s] <= quo_in;
            div_ff[s] <= div_src;
         end
      end
   end

   assign quotient    = quo_ff[STAGES-1];
   assign divisor_out = div_ff[STAGES-1];

endmodule

FILE: hdl/bwd_out.sv
// Output stage: pick the wiring scheme, form excite or inhibit terms, saturate, register.
module bwd_out #(
   parameter int RANGE_BITS = bwd_pkg::RANGE_BITS
) (
   input  logic                              clock,
   input  logic                              en,
   input  logic [bwd_pkg::WIRING_W-1:0]      wiring,
   input  logic                              polarity,
   input  logic [bwd_pkg::QUO_W-1:0]         inv_one_left,
   input  logic [bwd_pkg::QUO_W-1:0]         inv_one_right,
   input  logic [bwd_pkg::QUO_W-1:0]         inv_two_left,
   input  logic [bwd_pkg::QUO_W-1:0]         inv_two_right,
   input  logic [RANGE_BITS+1:0]             div_left,
   input  logic [RANGE_BITS+1:0]             div_right,
   input  logic [RANGE_BITS+1:0]             div_two_left,
   input  logic [RANGE_BITS+1:0]             div_two_right,
   output logic [bwd_pkg::SPEED_W-1:0]       left_speed,
   output logic [bwd_pkg::SPEED_W-1:0]       right_speed
);

   localparam int DW     = RANGE_BITS + 2;
   localparam int SW     = bwd_pkg::SPEED_W;
   localparam int WIDE_W = (RANGE_BITS + 11 > SW) ? RANGE_BITS + 11 : SW;
   localparam logic [WIDE_W-1:0] SPEED_MAX = WIDE_W'((64'd1 << SW) - 64'd1);
   localparam logic [WIDE_W-1:0] HALF      = WIDE_W'(64'd1 << 15);

   logic [WIDE_W-1:0] one_left;
   logic [WIDE_W-1:0] one_right;
   logic [DW:0]       range_sum;
   logic [WIDE_W-1:0] excite_sum;
   logic [WIDE_W-1:0] inhibit_left;
   logic [WIDE_W-1:0] inhibit_right;
   logic [WIDE_W-1:0] raw_left;
   logic [WIDE_W-1:0] raw_right;
   logic [SW-1:0]     left_speed_ff;
   logic [SW-1:0]     right_speed_ff;
   logic [SW-1:0]     left_speed_in;
   logic [SW-1:0]     right_speed_in;

   assign one_left   = WIDE_W'({div_left, 8'd0});
   assign one_right  = WIDE_W'({div_right, 8'd0});
   assign range_sum  = {1'b0, div_two_left} + {1'b0, div_two_right} - (DW+1)'(1024);
   assign excite_sum = WIDE_W'({range_sum, 8'd0}) + HALF;
   assign inhibit_left  = WIDE_W'(inv_one_right) + WIDE_W'(inv_two_left);
   assign inhibit_right = WIDE_W'(inv_one_left) + WIDE_W'(inv_two_right);

   always_comb begin
      case (wiring) inside
         bwd_pkg::WIRING_SAME: begin
            if (polarity == bwd_pkg::POLARITY_EXCITE) begin
               raw_left  = one_left;
               raw_right = one_right;
            end else begin
               raw_left  = WIDE_W'(inv_one_left);
               raw_right = WIDE_W'(inv_one_right);
            end
         end
         bwd_pkg::WIRING_CROSSED: begin
            if (polarity == bwd_pkg::POLARITY_EXCITE) begin
               raw_left  = one_right;
               raw_right = one_left;
            end else begin
               raw_left  = WIDE_W'(inv_one_right);
               raw_right = WIDE_W'(inv_one_left);
            end
         end
         default: begin
            if (polarity == bwd_pkg::POLARITY_EXCITE) begin
               raw_left  = excite_sum;
               raw_right = excite_sum;
            end else begin
               raw_left  = inhibit_left;
               raw_right = inhibit_right;
            end
         end
      endcase
   end

   assign left_speed_in  = (raw_left > SPEED_MAX)  ? SPEED_MAX[SW-1:0] : raw_left[SW-1:0];
   assign right_speed_in = (raw_right > SPEED_MAX) ? SPEED_MAX[SW-1:0] : raw_right[SW-1:0];

   always_ff @(posedge clock) begin
      if (en) begin
         left_speed_ff  <= left_speed_in;
         right_speed_ff <= right_speed_in;
      end
   end

   assign left_speed  = left_speed_ff;
   assign right_speed = right_speed_ff;

endmodule

FILE: hdl/braitenberg_wheel_drive.sv
// Top level of the wheel drive: handshake, configuration registers, pipeline.
//
// A request carries a left and a right range reading, unsigned Q8.8. The
// response carries left and right wheel speeds, unsigned with 16 fractional
// bits, saturated at 25 bits. Both channels use valid/ready.
// The csr port writes wiring (index 0) and polarity (index 1) with no wait;
// write them only while no request is in flight.
// The edge that accepts a request loads the first of ten registers (nine
// divider stages, two quotient bits each but one in the last, four
// dividers side by side, then the output register). Throughput is one
// request per cycle while the receiver keeps rsp_ready high.
// Every stage carries its own valid bit and moves when it is empty or the
// stage ahead moves, so a stalled receiver holds the response and the
// pipeline fills its bubbles before req_ready falls.
// Synchronous reset empties the pipeline and sets wiring and polarity to 0
// (same-side, inhibit).
module braitenberg_wheel_drive #(
   parameter int RANGE_BITS = bwd_pkg::RANGE_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [RANGE_BITS-1:0]              req_left_range,
   input  logic [RANGE_BITS-1:0]              req_right_range,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [bwd_pkg::SPEED_W-1:0]        rsp_left_speed,
   output logic [bwd_pkg::SPEED_W-1:0]        rsp_right_speed,
   input  logic                               csr_we,
   input  logic [bwd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bwd_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int STAGES = bwd_pkg::DIV_STAGES;
   localparam int PIPE   = STAGES + 1;
   localparam int DW     = RANGE_BITS + 2;
   localparam int QW     = bwd_pkg::QUO_W;

   logic [bwd_pkg::WIRING_W-1:0] wiring_ff;
   logic [bwd_pkg::WIRING_W-1:0] wiring_in;
   logic                         polarity_ff;
   logic                         polarity_in;
   logic [PIPE-1:0]              valid_ff;
   logic [PIPE-1:0]              valid_in;
   logic [PIPE-1:0]              adv;

   logic [DW-1:0] div_one_left;
   logic [DW-1:0] div_one_right;
   logic [DW-1:0] div_two_left;
   logic [DW-1:0] div_two_right;
   logic [DW-1:0] dl_out;
   logic [DW-1:0] dr_out;
   logic [DW-1:0] dl_two_out;
   logic [DW-1:0] dr_two_out;
   logic [QW-1:0] inv_one_left;
   logic [QW-1:0] inv_one_right;
   logic [QW-1:0] inv_two_left;
   logic [QW-1:0] inv_two_right;

   // configuration
   always_comb begin
      wiring_in   = wiring_ff;
      polarity_in = polarity_ff;
      if (csr_we) begin
         case (csr_index)
            bwd_pkg::IDX_WIRING:   wiring_in   = csr_wdata[bwd_pkg::WIRING_W-1:0];
            bwd_pkg::IDX_POLARITY: polarity_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wiring_ff   <= bwd_pkg::WIRING_SAME;
         polarity_ff <= bwd_pkg::POLARITY_INHIBIT;
      end else begin
         wiring_ff   <= wiring_in;
         polarity_ff <= polarity_in;
      end
   end

   // advance chain: a stage moves when it is empty or the stage ahead moves
   assign adv[PIPE-1] = !valid_ff[PIPE-1] || rsp_ready;
   for (genvar k = PIPE - 2; k >= 0; k--) begin : g_adv
      assign adv[k] = !valid_ff[k] || adv[k+1];
   end

   assign valid_in[0] = adv[0] ? req_valid : valid_ff[0];
   for (genvar k = 1; k < PIPE; k++) begin : g_valid
      assign valid_in[k] = adv[k] ? valid_ff[k-1] : valid_ff[k];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = adv[0];
   assign rsp_valid = valid_ff[PIPE-1];

   assign div_one_left  = DW'(req_left_range)  + DW'(256);
   assign div_one_right = DW'(req_right_range) + DW'(256);
   assign div_two_left  = DW'(req_left_range)  + DW'(512);
   assign div_two_right = DW'(req_right_range) + DW'(512);

   bwd_div #(.DIV_W(DW)) u_div_one_left (
      .clock       (clock),
      .en          (adv[STAGES-1:0]),
      .rem_init    (DW'(bwd_pkg::INIT_REM_ONE)),
      .divisor     (div_one_left),
      .quotient    (inv_one_left),
      .divisor_out (dl_out)
   );

   bwd_div #(.DIV_W(DW)) u_div_one_right (
      .clock       (clock),
      .en          (adv[STAGES-1:0]),
      .rem_init    (DW'(bwd_pkg::INIT_REM_ONE)),
      .divisor     (div_one_right),
      .quotient    (inv_one_right),
      .divisor_out (dr_out)
   );

   bwd_div #(.DIV_W(DW)) u_div_two_left (
      .clock       (clock),
      .en          (adv[STAGES-1:0]),
      .rem_init    (DW'(bwd_pkg::INIT_REM_TWO)),
      .divisor     (div_two_left),
      .quotient    (inv_two_left),
      .divisor_out (dl_two_out)
   );

   bwd_div #(.DIV_W(DW)) u_div_two_right (
      .clock       (clock),
      .en          (adv[STAGES-1:0]),
      .rem_init    (DW'(bwd_pkg::INIT_REM_TWO)),
      .divisor     (div_two_right),
      .quotient    (inv_two_right),
      .divisor_out (dr_two_out)
   );

   bwd_out #(.RANGE_BITS(RANGE_BITS)) u_out (
      .clock         (clock),
      .en            (adv[PIPE-1]),
      .wiring        (wiring_ff),
      .polarity      (polarity_ff),
      .inv_one_left  (inv_one_left),
      .inv_one_right (inv_one_right),
      .inv_two_left  (inv_two_left),
      .inv_two_right (inv_two_right),
      .div_left      (dl_out),
      .div_right     (dr_out),
      .div_two_left  (dl_two_out),
      .div_two_right (dr_two_out),
      .left_speed    (rsp_left_speed),
      .right_speed   (rsp_right_speed)
   );

endmodule
